// File: sv/dbgq_pkg.sv
package dbgq_pkg;

   // Queue geometry and event type space
   localparam int QUEUE_DEPTH = 16;
   localparam int EVENT_TYPES = 32;
   localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Outstanding client requests saturate here
   localparam logic [7:0] OUTSTANDING_MAX = 8'hFF;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTION_TABLE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AGENT_PID      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRITICAL_SLOTS = 2'd2;
   localparam logic [4:0] CRITICAL_SLOTS_RESET = 5'd4;

   // Item operations
   localparam logic [1:0] OP_NOTIFY  = 2'd0;
   localparam logic [1:0] OP_REQUEST = 2'd1;
   localparam logic [1:0] OP_CANCEL  = 2'd2;

   // Per-type actions
   localparam logic [1:0] ACT_IGNORE   = 2'd0;
   localparam logic [1:0] ACT_SUSPEND  = 2'd1;
   localparam logic [1:0] ACT_CONTINUE = 2'd2;

   // Event type codes
   localparam logic [4:0] EVT_SW_EXC       = 5'd1;
   localparam logic [4:0] EVT_HW_EXC       = 5'd2;
   localparam logic [4:0] EVT_KILL         = 5'd3;
   localparam logic [4:0] EVT_BKPT         = 5'd4;
   localparam logic [4:0] EVT_PROC_BKPT    = 5'd5;
   localparam logic [4:0] EVT_LIB_ADDED    = 5'd6;
   localparam logic [4:0] EVT_LIB_REMOVED  = 5'd7;
   localparam logic [4:0] EVT_TRACE        = 5'd8;
   localparam logic [4:0] EVT_TRACES_LOST  = 5'd9;
   localparam logic [4:0] EVT_BUFFER_FULL  = 5'd10;

   typedef struct packed {
      logic [1:0]  operation;
      logic [4:0]  event_type;
      logic [63:0] process_id;
      logic [63:0] thread_id;
      logic [63:0] current_thread_id;
      logic [3:0]  thread_flags;
      logic        exit_is_kill;
      logic [63:0] event_payload;
   } req_type;

   typedef struct packed {
      logic        delivered;
      logic [4:0]  delivered_type;
      logic [1:0]  delivered_action;
      logic [63:0] delivered_thread;
      logic [63:0] delivered_payload;
      logic        suspend_request;
      logic [63:0] suspend_thread;
      logic        cancelled;
   } rsp_type;

   typedef struct packed {
      logic [4:0]  etype;
      logic [1:0]  action;
      logic [63:0] thread;
      logic [63:0] payload;
   } queue_entry_type;

   // Shared comparator operands and flags
   typedef struct packed {
      logic [63:0] lhs;
      logic [63:0] rhs;
   } cmp_req_type;

   typedef struct packed {
      logic eq;
      logic le;
   } cmp_rsp_type;

endpackage

// File: sv/dbgq_cmp.sv
module dbgq_cmp (
   input  dbgq_pkg::cmp_req_type cmp_req,
   output dbgq_pkg::cmp_rsp_type cmp_rsp
);
   import dbgq_pkg::*;

   // One 64-bit comparator, time-shared by the sequencer
   always_comb begin
      cmp_rsp.eq = (cmp_req.lhs == cmp_req.rhs);
      cmp_rsp.le = (cmp_req.lhs <= cmp_req.rhs);
   end

endmodule

// File: sv/debug_event_queue.sv
// Channel  | Direction | Handshake             | Beat
// ---------+-----------+-----------------------+-------------------------------
// req_     | in        | req_valid / req_stall | notify, request or cancel item
// rsp_     | out       | rsp_valid / rsp_stall | one result per item
// csr_     | in        | csr_we (no wait)      | register write, index + data
//
// An item runs S_CHECK then S_RESULT (cancel, unused item, ignored notify, or a
// request on an empty queue), adds S_FETCH (request served from the queue) or
// S_PUSH (stored notify with no hand-out), or runs S_PUSH then S_FETCH (notify
// with hand-out); the result register loads as the sequencer returns to S_IDLE,
// where the next item can be taken. The sequencer walks the shared comparator up
// to twice and reads the queue memory in S_FETCH.
// Reset is synchronous and active high; the queue is empty after reset and
// needs no clearing pass. req_stall is high while an item is in flight.
// A stalled result holds in the output register while the next item is
// taken; that item then waits at its final step until the register frees.
module debug_event_queue (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  dbgq_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output dbgq_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [dbgq_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [63:0]                           csr_wdata
);
   import dbgq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_PUSH,
      S_FETCH,
      S_RESULT
   } state_type;

   // Sequencer and item registers
   state_type       state_ff, state_in;
   req_type         req_ff, req_in;
   rsp_type         res_ff, res_in;
   logic [1:0]      action_ff, action_in;
   logic            deliver_ff, deliver_in;
   queue_entry_type rd_entry_ff;
   rsp_type         rsp_data_ff, rsp_data_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Queue bookkeeping
   logic [QIDX_W-1:0] head_ff, head_in;
   logic [QIDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  free_ff, free_in;
   logic              ign_traces_ff, ign_traces_in;
   logic              dying_ff, dying_in;
   logic [7:0]        outst_ff, outst_in;
   logic              client_ff, client_in;

   // Configuration
   logic [63:0] act_table_ff, act_table_in;
   logic [63:0] agent_pid_ff, agent_pid_in;
   logic [4:0]  crit_slots_ff, crit_slots_in;

   // Entry memory
   queue_entry_type entry_mem_ff [QUEUE_DEPTH];
   logic            mem_we;
   queue_entry_type mem_wentry;

   // Shared comparator
   cmp_req_type cmp_req;
   cmp_rsp_type cmp_rsp;

   // Decode helpers
   logic             type_ok;
   logic             agent_type;
   logic             crit_flag;
   logic             perm_flag;
   logic [1:0]       act_raw;
   logic [1:0]       act_eff;
   logic             critical;
   logic             push;
   logic [CNT_W-1:0] free_after;
   logic             out_free;

   dbgq_cmp u_cmp (
      .cmp_req (cmp_req),
      .cmp_rsp (cmp_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Item decode, all from the held item
   assign type_ok    = (int'(req_ff.event_type) < EVENT_TYPES);
   assign agent_type = (req_ff.event_type == EVT_SW_EXC) ||
                       (req_ff.event_type == EVT_HW_EXC) ||
                       (req_ff.event_type == EVT_KILL);
   assign crit_flag  = (req_ff.thread_flags[1:0] != 2'b00) &&
                       ((req_ff.event_type != EVT_KILL) || !req_ff.exit_is_kill);
   assign perm_flag  = (req_ff.thread_flags[3:2] != 2'b00);
   assign act_raw    = act_table_ff[{req_ff.event_type, 1'b0} +: 2];

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      res_in        = res_ff;
      action_in     = action_ff;
      deliver_in    = deliver_ff;
      rsp_data_in   = rsp_data_ff;
      // drop the result once the consumer takes it
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_in       = free_ff;
      ign_traces_in = ign_traces_ff;
      dying_in      = dying_ff;
      outst_in      = outst_ff;
      client_in     = client_ff;
      act_table_in  = act_table_ff;
      agent_pid_in  = agent_pid_ff;
      crit_slots_in = crit_slots_ff;
      mem_we        = 1'b0;
      mem_wentry    = '{etype: req_ff.event_type, action: action_ff,
                        thread: req_ff.thread_id, payload: req_ff.event_payload};
      critical      = 1'b0;
      push          = 1'b0;
      free_after    = free_ff;
      act_eff       = ACT_IGNORE;

      // The comparator checks the agent pid at S_CHECK and the free level at S_PUSH
      cmp_req.lhs = req_ff.process_id;
      cmp_req.rhs = agent_pid_ff;
      if (state_ff == S_PUSH) begin
         cmp_req.lhs = 64'(free_ff);
         cmp_req.rhs = 64'(crit_slots_ff);
      end

      if (csr_we) begin
         case (csr_index)
            CSR_ACTION_TABLE:   act_table_in  = csr_wdata;
            CSR_AGENT_PID:      agent_pid_in  = csr_wdata;
            CSR_CRITICAL_SLOTS: crit_slots_in = csr_wdata[4:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in     = req_data;
               res_in     = '0;
               deliver_in = 1'b0;
               state_in   = S_CHECK;
            end
         end

         S_CHECK: begin
            state_in = S_RESULT;
            case (req_ff.operation)
               OP_NOTIFY: begin
                  if (type_ok) begin
                     // dying is sticky; a crash of the agent itself sets it
                     if (cmp_rsp.eq && agent_type && (crit_flag || perm_flag)) begin
                        dying_in = 1'b1;
                     end
                     act_eff = (act_raw == ACT_SUSPEND || act_raw == ACT_CONTINUE)
                               ? act_raw : ACT_IGNORE;
                     if (dying_in && act_eff == ACT_SUSPEND) begin
                        act_eff = ACT_IGNORE;
                     end
                     if (act_eff != ACT_IGNORE) begin
                        action_in = act_eff;
                        if (act_eff == ACT_SUSPEND && req_ff.event_type != EVT_BKPT &&
                            req_ff.event_type != EVT_PROC_BKPT) begin
                           res_in.suspend_request = 1'b1;
                           res_in.suspend_thread  =
                              (req_ff.event_type == EVT_LIB_ADDED ||
                               req_ff.event_type == EVT_LIB_REMOVED)
                              ? req_ff.thread_id : req_ff.current_thread_id;
                        end
                        state_in = S_PUSH;
                     end
                  end
               end
               OP_REQUEST: begin
                  client_in = 1'b1;
                  if (free_ff < CNT_W'(QUEUE_DEPTH)) begin
                     deliver_in = 1'b1;
                     state_in   = S_FETCH;
                  end else if (outst_ff != OUTSTANDING_MAX) begin
                     outst_in = outst_ff + 8'd1;
                  end
               end
               OP_CANCEL: begin
                  res_in.cancelled = (outst_ff != 8'd0);
                  outst_in         = 8'd0;
                  client_in        = 1'b0;
               end
               default: ;
            endcase
         end

         S_PUSH: begin
            critical = cmp_rsp.le;
            if (free_ff != '0) begin
               if (!critical) begin
                  ign_traces_in = 1'b0;
                  push          = 1'b1;
               end else if (free_ff > CNT_W'(1)) begin
                  // collapse a run of traces into one traces-lost marker
                  if (req_ff.event_type == EVT_TRACE) begin
                     if (!ign_traces_ff) begin
                        push          = 1'b1;
                        mem_wentry    = '{etype: EVT_TRACES_LOST, action: ACT_IGNORE,
                                          thread: '0, payload: '0};
                        ign_traces_in = 1'b1;
                     end
                  end else begin
                     push = 1'b1;
                  end
               end else begin
                  // last slot: store the buffer-full marker instead
                  push       = 1'b1;
                  mem_wentry = '{etype: EVT_BUFFER_FULL, action: ACT_IGNORE,
                                 thread: '0, payload: '0};
               end
            end
            mem_we = push;
            if (push) begin
               head_in    = (head_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : head_ff + QIDX_W'(1);
               free_after = free_ff - CNT_W'(1);
            end
            free_in = free_after;
            // serve a waiting client straight away
            if (client_ff && outst_ff != 8'd0 && free_after < CNT_W'(QUEUE_DEPTH)) begin
               outst_in   = outst_ff - 8'd1;
               deliver_in = 1'b1;
               state_in   = S_FETCH;
            end else begin
               state_in = S_RESULT;
            end
         end

         S_FETCH: begin
            // the tail entry is read into rd_entry_ff at this edge
            tail_in  = (tail_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + QIDX_W'(1);
            free_in  = free_ff + CNT_W'(1);
            state_in = S_RESULT;
         end

         S_RESULT: begin
            // hold here until the output register frees
            if (out_free) begin
               rsp_data_in = res_ff;
               if (deliver_ff) begin
                  rsp_data_in.delivered         = 1'b1;
                  rsp_data_in.delivered_type    = rd_entry_ff.etype;
                  rsp_data_in.delivered_action  = rd_entry_ff.action;
                  rsp_data_in.delivered_thread  = rd_entry_ff.thread;
                  rsp_data_in.delivered_payload = rd_entry_ff.payload;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      action_ff   <= action_in;
      deliver_ff  <= deliver_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         free_ff       <= CNT_W'(QUEUE_DEPTH);
         ign_traces_ff <= 1'b0;
         dying_ff      <= 1'b0;
         outst_ff      <= 8'd0;
         client_ff     <= 1'b0;
         act_table_ff  <= 64'd0;
         agent_pid_ff  <= 64'd0;
         crit_slots_ff <= CRITICAL_SLOTS_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         free_ff       <= free_in;
         ign_traces_ff <= ign_traces_in;
         dying_ff      <= dying_in;
         outst_ff      <= outst_in;
         client_ff     <= client_in;
         act_table_ff  <= act_table_in;
         agent_pid_ff  <= agent_pid_in;
         crit_slots_ff <= crit_slots_in;
      end
   end

   // Entry memory: one write port at head, one registered read port at tail
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[head_ff] <= mem_wentry;
      end
      if (state_ff == S_FETCH) begin
         rd_entry_ff <= entry_mem_ff[tail_ff];
      end
   end

endmodule
